### design/assert_macros.svh
// Assertion macros shared by the block pool cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define AST_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/bpc_pkg.sv
// Shared types and constants of the two-level block pool cache.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

	localparam int BATCH_W     = 7;
	localparam int IDX_W       = 8;
	localparam int CNT_OUT_W   = 9;
	localparam int S_TDATA_W   = 8;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 32;
	localparam int M_TUSER_W   = 2;
	localparam int M_TDATA_PAD = M_TDATA_W - IDX_W - 2 * CNT_OUT_W;

	localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd16;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_ALLOC   = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_FREED   = 2'd2,
		STAT_IGNORED = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_FLUSH_CHECK,
		S_MOVE,
		S_DRAIN,
		S_CHECK,
		S_POP_WAIT,
		S_DONE
	} ctl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic  latch_in;
		logic  plan_refill;
		logic  plan_flush;
		logic  move_step;
		logic  move_finish;
		logic  push_local;
		logic  pop_issue;
		logic  pop_capture;
		logic  set_stat;
		stat_t stat_code;
		logic  out_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic cmd_free;
		logic free_ok;
		logic low_mark;
		logic high_mark;
		logic local_empty;
		logic mv_left_zero;
		logic mv_left_one;
		logic mv_to_global;
		logic out_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

### design/bpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### design/bpc_ctrl.sv
// Sequencing state machine of the block pool cache.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bpc_pkg::dp_stat_t stat,
	output bpc_pkg::dp_cmd_t       cmd
);

	bpc_pkg::ctl_state_t state_q;
	bpc_pkg::ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.stat_code = bpc_pkg::STAT_ALLOC;
		case (state_q)
			bpc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = bpc_pkg::S_DECIDE;
				end
			end
			bpc_pkg::S_DECIDE: begin
				if (!stat.cmd_free) begin
					if (stat.low_mark) begin
						cmd.plan_refill = 1'b1;
						state_d         = bpc_pkg::S_MOVE;
					end else begin
						state_d = bpc_pkg::S_CHECK;
					end
				end else if (stat.free_ok) begin
					cmd.push_local = 1'b1;
					state_d        = bpc_pkg::S_FLUSH_CHECK;
				end else begin
					cmd.set_stat  = 1'b1;
					cmd.stat_code = bpc_pkg::STAT_IGNORED;
					state_d       = bpc_pkg::S_DONE;
				end
			end
			bpc_pkg::S_FLUSH_CHECK: begin
				if (stat.high_mark) begin
					cmd.plan_flush = 1'b1;
					state_d        = bpc_pkg::S_MOVE;
				end else begin
					cmd.set_stat  = 1'b1;
					cmd.stat_code = bpc_pkg::STAT_FREED;
					state_d       = bpc_pkg::S_DONE;
				end
			end
			bpc_pkg::S_MOVE: begin
				if (stat.mv_left_zero) begin
					state_d = bpc_pkg::S_DRAIN;
				end else begin
					cmd.move_step = 1'b1;
					if (stat.mv_left_one) begin
						state_d = bpc_pkg::S_DRAIN;
					end
				end
			end
			bpc_pkg::S_DRAIN: begin
				cmd.move_finish = 1'b1;
				if (stat.mv_to_global) begin
					cmd.set_stat  = 1'b1;
					cmd.stat_code = bpc_pkg::STAT_FREED;
					state_d       = bpc_pkg::S_DONE;
				end else begin
					state_d = bpc_pkg::S_CHECK;
				end
			end
			bpc_pkg::S_CHECK: begin
				if (stat.local_empty) begin
					cmd.set_stat  = 1'b1;
					cmd.stat_code = bpc_pkg::STAT_EMPTY;
					state_d       = bpc_pkg::S_DONE;
				end else begin
					cmd.pop_issue = 1'b1;
					state_d       = bpc_pkg::S_POP_WAIT;
				end
			end
			bpc_pkg::S_POP_WAIT: begin
				cmd.pop_capture = 1'b1;
				cmd.set_stat    = 1'b1;
				cmd.stat_code   = bpc_pkg::STAT_ALLOC;
				state_d         = bpc_pkg::S_DONE;
			end
			bpc_pkg::S_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = bpc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpc_pkg::S_IDLE;
			end
		endcase
	end

	`AST_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_q == bpc_pkg::S_DECIDE, "accepted transaction did not start decode")
	`AST_IMPLY(a_single_move_cmd, cmd.move_step, !cmd.pop_issue && !cmd.push_local, "move overlaps a pop or push")

endmodule
`default_nettype wire

### design/bpc_dp.sv
// Datapath of the block pool cache: depths, both stacks, move engine, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpc_dp #(
	parameter int POOL_BLOCKS = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [bpc_pkg::BATCH_W-1:0]       cfg_wdata,
	input  wire logic [bpc_pkg::S_TDATA_W-1:0]     in_data,
	input  wire logic [bpc_pkg::S_TUSER_W-1:0]     in_user,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [bpc_pkg::M_TDATA_W-1:0]     out_data,
	output logic      [bpc_pkg::M_TUSER_W-1:0]     out_user,
	input  wire bpc_pkg::dp_cmd_t                  cmd,
	output bpc_pkg::dp_stat_t                      stat
);

	localparam int AW = $clog2(POOL_BLOCKS);
	localparam int CW = $clog2(POOL_BLOCKS + 1);
	localparam int XW = CW + 8;
	localparam logic [CW-1:0] N_C = CW'(POOL_BLOCKS);
	localparam logic [XW-1:0] N_X = XW'(POOL_BLOCKS);

	// latched transaction
	logic                          cmd_q;
	logic [bpc_pkg::IDX_W-1:0]     idx_q;
	logic                          null_q;

	logic [bpc_pkg::BATCH_W-1:0]   batch_q;
	logic [CW-1:0]                 ldepth_q;
	logic [CW-1:0]                 gdepth_q;
	logic [CW-1:0]                 gmin_q;

	// move engine
	logic                          mv_dir_q;
	logic [CW-1:0]                 mv_cnt_q;
	logic [CW-1:0]                 mv_left_q;
	logic [CW-1:0]                 mv_src_q;
	logic [CW-1:0]                 mv_dst_q;
	logic                          rd_pend_s1;
	logic                          fill_s1;
	logic [bpc_pkg::IDX_W-1:0]     fill_val_s1;

	logic [bpc_pkg::IDX_W-1:0]     granted_q;
	bpc_pkg::stat_t                status_q;

	logic                          out_valid_q;
	logic [bpc_pkg::M_TDATA_W-1:0] out_data_q;
	logic [bpc_pkg::M_TUSER_W-1:0] out_user_q;

	logic [XW-1:0] ldepth_x, gdepth_x, batch_x, idx_x;
	logic [XW-1:0] rf_c1, room_l, room_g, excess;
	logic [CW-1:0] refill_cnt, flush_cnt, ldepth_dec, new_gtop;

	logic                      lram_we, lram_re, gram_we, gram_re;
	logic [AW-1:0]             lram_waddr, lram_raddr;
	logic [bpc_pkg::IDX_W-1:0] lram_wdata, lram_rdata, gram_rdata, move_data;

	always_comb begin
		ldepth_x   = XW'(ldepth_q);
		gdepth_x   = XW'(gdepth_q);
		batch_x    = XW'(batch_q);
		idx_x      = XW'(idx_q);
		rf_c1      = (batch_x < gdepth_x) ? batch_x : gdepth_x;
		room_l     = N_X - ldepth_x;
		room_g     = N_X - gdepth_x;
		excess     = ldepth_x - batch_x;
		refill_cnt = CW'((rf_c1 < room_l) ? rf_c1 : room_l);
		flush_cnt  = CW'((excess < room_g) ? excess : room_g);
		ldepth_dec = ldepth_q - CW'(1);
		new_gtop   = gdepth_q - mv_cnt_q;
	end

	assign stat.cmd_free     = (cmd_q == bpc_pkg::CMD_FREE);
	assign stat.free_ok      = !null_q && (idx_x < N_X) && (ldepth_q != N_C);
	assign stat.low_mark     = ldepth_x <= (batch_x >> 1);
	assign stat.high_mark    = ldepth_x > (batch_x << 1);
	assign stat.local_empty  = (ldepth_q == '0);
	assign stat.mv_left_zero = (mv_left_q == '0);
	assign stat.mv_left_one  = (mv_left_q == CW'(1));
	assign stat.mv_to_global = mv_dir_q;
	assign stat.out_busy     = out_valid_q && !out_ready;

	// reads below the low-water mark of the global stack return their own index, not RAM data
	assign move_data = mv_dir_q ? lram_rdata : (fill_s1 ? fill_val_s1 : gram_rdata);

	assign lram_we    = cmd.push_local || (rd_pend_s1 && !mv_dir_q);
	assign lram_waddr = cmd.push_local ? ldepth_q[AW-1:0] : mv_dst_q[AW-1:0];
	assign lram_wdata = cmd.push_local ? idx_q : move_data;
	assign lram_re    = cmd.pop_issue || (cmd.move_step && mv_dir_q);
	assign lram_raddr = cmd.pop_issue ? ldepth_dec[AW-1:0] : mv_src_q[AW-1:0];
	assign gram_we    = rd_pend_s1 && mv_dir_q;
	assign gram_re    = cmd.move_step && !mv_dir_q;

	bpc_ram #(
		.WIDTH (bpc_pkg::IDX_W),
		.DEPTH (POOL_BLOCKS)
	) u_local_ram (
		.clk   (clk),
		.we    (lram_we),
		.waddr (lram_waddr),
		.wdata (lram_wdata),
		.re    (lram_re),
		.raddr (lram_raddr),
		.rdata (lram_rdata)
	);

	bpc_ram #(
		.WIDTH (bpc_pkg::IDX_W),
		.DEPTH (POOL_BLOCKS)
	) u_global_ram (
		.clk   (clk),
		.we    (gram_we),
		.waddr (mv_dst_q[AW-1:0]),
		.wdata (move_data),
		.re    (gram_re),
		.raddr (mv_src_q[AW-1:0]),
		.rdata (gram_rdata)
	);

	// control and depth state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_q     <= bpc_pkg::BATCH_RESET;
			ldepth_q    <= '0;
			gdepth_q    <= N_C;
			gmin_q      <= N_C;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				batch_q <= cfg_wdata;
			end
			rd_pend_s1 <= cmd.move_step;
			if (cmd.push_local) begin
				ldepth_q <= ldepth_q + CW'(1);
			end else if (cmd.pop_issue) begin
				ldepth_q <= ldepth_dec;
			end else if (cmd.move_finish) begin
				if (mv_dir_q) begin
					ldepth_q <= ldepth_q - mv_cnt_q;
					gdepth_q <= gdepth_q + mv_cnt_q;
				end else begin
					ldepth_q <= ldepth_q + mv_cnt_q;
					gdepth_q <= new_gtop;
					if (new_gtop < gmin_q) begin
						gmin_q <= new_gtop;
					end
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			idx_q     <= in_data[bpc_pkg::IDX_W-1:0];
			cmd_q     <= in_user[0];
			null_q    <= in_user[1];
			granted_q <= '0;
		end
		if (cmd.plan_refill) begin
			mv_dir_q  <= 1'b0;
			mv_cnt_q  <= refill_cnt;
			mv_left_q <= refill_cnt;
			mv_src_q  <= gdepth_q - refill_cnt;
			mv_dst_q  <= ldepth_q;
		end else if (cmd.plan_flush) begin
			mv_dir_q  <= 1'b1;
			mv_cnt_q  <= flush_cnt;
			mv_left_q <= flush_cnt;
			mv_src_q  <= ldepth_q - flush_cnt;
			mv_dst_q  <= gdepth_q;
		end else if (cmd.move_step) begin
			mv_src_q  <= mv_src_q + CW'(1);
			mv_left_q <= mv_left_q - CW'(1);
		end
		if (cmd.move_step) begin
			fill_s1     <= mv_src_q < gmin_q;
			fill_val_s1 <= bpc_pkg::IDX_W'(mv_src_q);
		end
		if (rd_pend_s1) begin
			mv_dst_q <= mv_dst_q + CW'(1);
		end
		if (cmd.pop_capture) begin
			granted_q <= lram_rdata;
		end
		if (cmd.set_stat) begin
			status_q <= cmd.stat_code;
		end
		if (cmd.out_load) begin
			out_user_q <= status_q;
			out_data_q <= {{bpc_pkg::M_TDATA_PAD{1'b0}},
				bpc_pkg::CNT_OUT_W'(gdepth_q),
				bpc_pkg::CNT_OUT_W'(ldepth_q),
				granted_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	`AST_ALWAYS(a_local_depth_range, ldepth_q <= N_C, "local depth above pool size")
	`AST_ALWAYS(a_global_depth_range, gdepth_q <= N_C, "global depth above pool size")
	`AST_ALWAYS(a_fill_mark_below_top, gmin_q <= gdepth_q, "global fill mark above global top")
	`AST_IMPLY(a_move_write_in_range, rd_pend_s1, mv_dst_q < N_C, "move writes past stack end")

endmodule
`default_nettype wire

### design/two_level_block_pool_cache.sv
// Top level of the two-level block pool cache: controller plus datapath.
// Throughput: one transaction at a time; the move engine shifts one block per cycle
// over the RAM ports during a refill or flush.
// Reset: arst_n clears depths and control; the global stack reads as 0..N-1 with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module two_level_block_pool_cache #(
	parameter int POOL_BLOCKS = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration: refill batch length
	input  wire logic                              cfg_we,
	input  wire logic [bpc_pkg::BATCH_W-1:0]       cfg_wdata,
	// request stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [bpc_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] block_index
	input  wire logic [bpc_pkg::S_TUSER_W-1:0]     s_tuser,  // [0] cmd, [1] is_null
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [bpc_pkg::M_TDATA_W-1:0]     m_tdata,  // [7:0] granted_index,
	                                                         // [16:8] local_count,
	                                                         // [25:17] global_count, rest 0
	output logic      [bpc_pkg::M_TUSER_W-1:0]     m_tuser   // [1:0] status
);

	// Commands and status between the sequencer and the datapath.
	bpc_pkg::dp_cmd_t  dp_cmd;
	bpc_pkg::dp_stat_t dp_stat;

	// The sequencer takes one transaction at a time: decode, push for a free, optional
	// refill or flush through the move engine, pop for an allocation, then load the output register.
	// The output register lets the next request be taken while a result waits.
	bpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// Both free stacks live in RAMs; the global one tracks a low-water mark so that
	// entries never overwritten since reset read as their own index.
	bpc_dp #(
		.POOL_BLOCKS (POOL_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

endmodule
`default_nettype wire
